### sv/skf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skf_pkg
// Shared constants and register codes for the scalar Kalman filter block.
// ----------------------------------------------------------------------------
package skf_pkg;

  // default fixed-point format of the internal words
  localparam int FRAC_BITS_DEF = 16;
  localparam int WORD_BITS_DEF = 32;

  // port widths
  localparam int FIELD_W = 32;
  localparam int NOISE_W = 31;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 4;

  // register map, one 32-bit register every 4 bytes
  typedef enum logic [1:0] {
    REG_A_COEF  = 2'd0,
    REG_C_COEF  = 2'd1,
    REG_Q_NOISE = 2'd2,
    REG_R_NOISE = 2'd3
  } cfg_reg_e;

  localparam logic [FIELD_W-1:0] A_COEF_RESET  = 32'd65536;
  localparam logic [FIELD_W-1:0] C_COEF_RESET  = 32'd65536;
  localparam logic [NOISE_W-1:0] Q_NOISE_RESET = 31'd655;
  localparam logic [NOISE_W-1:0] R_NOISE_RESET = 31'd65536;

endpackage

### sv/scalar_kalman_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scalar_kalman_filter
// One-state Kalman filter in saturating signed fixed point, built around one
// shared radix-4 serial multiplier and one radix-2 restoring divider.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake               | payload
//  ----------+-----------+-------------------------+----------------------------
//  in        | input     | in_valid_i / in_stall_o | measurement_i
//  out       | output    | out_valid_o/out_stall_i | filtered_o, divide_fault_o
//  config    | input     | psel/penable/pwrite     | paddr, pwdata, prdata
//
//  One measurement runs eleven products and a gain divide, in Q16.16 by
//  default. The products share the serial multiplier (MW = W rounded up
//  to even, two bits a cycle) and the gain divide retires one quotient bit a
//  cycle. A zero gain denominator skips the divide.
//  Reset and any register write set the estimate to zero and the variance to Q.
//  A finished word waits in the output register while the next one is taken.
// ----------------------------------------------------------------------------
module scalar_kalman_filter #(
  parameter int FRAC_BITS = skf_pkg::FRAC_BITS_DEF,
  parameter int WORD_BITS = skf_pkg::WORD_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // measurement channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [skf_pkg::FIELD_W-1:0] measurement_i,
  // result channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [skf_pkg::FIELD_W-1:0] filtered_o,
  output logic                        divide_fault_o,
  // register port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [skf_pkg::ADDR_W-1:0]  paddr,
  input  logic [skf_pkg::DATA_W-1:0]  pwdata,
  output logic [skf_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  localparam int W      = WORD_BITS;
  localparam int F      = FRAC_BITS;
  localparam int MW     = 2 * ((W + 1) / 2);
  localparam int PW     = W + MW;
  localparam int EW     = (W > 32) ? W : 32;
  localparam int STEPS  = MW / 2;
  localparam int DSTEPS = W + F;
  localparam int CW     = $clog2(DSTEPS);

  localparam logic [W-1:0] WMAX  = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] WMIN  = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] ONE_W = (F <= W - 2) ? (W'(1) << F) : WMAX;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_MUL,
    ST_MRND,
    ST_DIV,
    ST_DRND,
    ST_FIN,
    ST_POST,
    ST_DONE
  } state_e;

  // one entry per arithmetic step of the recursion
  typedef enum logic [3:0] {
    OP_AA,     // A*A
    OP_XP,     // predicted estimate A*x
    OP_PPRED,  // predicted variance A*A*P + Q
    OP_CC,     // C*C
    OP_NUM,    // gain numerator P*C
    OP_DEN,    // gain denominator C*C*P + R
    OP_GAIN,   // K = num / den
    OP_INNOV,  // y - C*xp
    OP_EST,    // xp + K*innov
    OP_KC,     // 1 - K*C
    OP_PUPD,   // updated variance
    OP_OUT     // C*x
  } op_e;

  // ---------------------------------------------------------------- helpers
  function automatic logic [W-1:0] sat_in(input logic [31:0] v);
    logic [EW-1:0] e;
    logic [EW-1:0] hi_e;
    logic [EW-1:0] lo_e;
    e    = EW'($signed(v));
    hi_e = EW'($signed(WMAX));
    lo_e = EW'($signed(WMIN));
    if ($signed(e) > $signed(hi_e)) begin
      return WMAX;
    end else if ($signed(e) < $signed(lo_e)) begin
      return WMIN;
    end
    return e[W-1:0];
  endfunction

  function automatic logic [31:0] sat_out(input logic [W-1:0] v);
    logic [EW-1:0] e;
    logic [EW-1:0] hi_e;
    logic [EW-1:0] lo_e;
    e    = EW'($signed(v));
    hi_e = EW'(32'sh7FFF_FFFF);
    lo_e = EW'(32'sh8000_0000);
    if ($signed(e) > $signed(hi_e)) begin
      return 32'h7FFF_FFFF;
    end else if ($signed(e) < $signed(lo_e)) begin
      return 32'h8000_0000;
    end
    return e[31:0];
  endfunction

  function automatic logic [W-1:0] mag(input logic [W-1:0] v);
    return v[W-1] ? (W'(0) - v) : v;
  endfunction

  function automatic logic [W-1:0] sat_addsub(input logic [W-1:0] a,
                                              input logic [W-1:0] b,
                                              input logic         sub);
    logic [W:0] s;
    s = sub ? ({a[W-1], a} - {b[W-1], b}) : ({a[W-1], a} + {b[W-1], b});
    if (s[W] != s[W-1]) begin
      return s[W] ? WMIN : WMAX;
    end
    return s[W-1:0];
  endfunction

  // ------------------------------------------------------------- registers
  state_e            state_q, state_d;
  op_e               op_q, op_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              fault_q, fault_d;
  logic              out_valid_q, out_valid_d;
  logic [31:0]       filtered_q, filtered_d;
  logic              fault_out_q, fault_out_d;
  logic [31:0]       a_coef_q, a_coef_d;
  logic [31:0]       c_coef_q, c_coef_d;
  logic [30:0]       q_noise_q, q_noise_d;
  logic [30:0]       r_noise_q, r_noise_d;
  logic [W-1:0]      est_q, est_d;
  logic [W-1:0]      pvar_q, pvar_d;

  logic [W-1:0]      y_q, y_d;
  logic [W-1:0]      sq_q, sq_d;
  logic [W-1:0]      xp_q, xp_d;
  logic [W-1:0]      p_q, p_d;
  logic [W-1:0]      ra_q, ra_d;
  logic [W-1:0]      rb_q, rb_d;
  logic [W-1:0]      k_q, k_d;
  logic [W-1:0]      t_q, t_d;
  logic [W-1:0]      mx_q, mx_d;
  logic              neg_q, neg_d;
  logic [PW-1:0]     prod_q, prod_d;
  logic [W-1:0]      rem_q, rem_d;
  logic [W+F-1:0]    quo_q, quo_d;

  // ------------------------------------------------------------ datapath
  logic [W-1:0]      a_w, c_w, q_w, r_w;
  logic [W-1:0]      opa, opb;
  logic              cfg_wr;
  skf_pkg::cfg_reg_e cfg_idx;
  logic [W+1:0]      mul_add, mul_sum;
  logic [PW:0]       rnd;
  logic [W:0]        div_sh, div_diff;
  logic              div_ge;
  logic              div_up;
  logic [W+F:0]      quo_up;
  logic [W-1:0]      limit, mag_r;
  logic              over;
  logic [W-1:0]      post;

  assign a_w = sat_in(a_coef_q);
  assign c_w = sat_in(c_coef_q);
  assign q_w = sat_in({1'b0, q_noise_q});
  assign r_w = sat_in({1'b0, r_noise_q});

  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = skf_pkg::cfg_reg_e'(paddr[3:2]);
  assign pready  = 1'b1;

  always_comb begin
    case (cfg_idx)
      skf_pkg::REG_A_COEF:  prdata = a_coef_q;
      skf_pkg::REG_C_COEF:  prdata = c_coef_q;
      skf_pkg::REG_Q_NOISE: prdata = {1'b0, q_noise_q};
      skf_pkg::REG_R_NOISE: prdata = {1'b0, r_noise_q};
      default:              prdata = '0;
    endcase
  end

  // operand selection for the current step
  always_comb begin
    case (op_q)
      OP_AA:    begin opa = a_w;  opb = a_w;    end
      OP_XP:    begin opa = a_w;  opb = est_q;  end
      OP_PPRED: begin opa = sq_q; opb = pvar_q; end
      OP_CC:    begin opa = c_w;  opb = c_w;    end
      OP_NUM:   begin opa = p_q;  opb = c_w;    end
      OP_DEN:   begin opa = sq_q; opb = p_q;    end
      OP_GAIN:  begin opa = ra_q; opb = rb_q;   end
      OP_INNOV: begin opa = c_w;  opb = xp_q;   end
      OP_EST:   begin opa = k_q;  opb = ra_q;   end
      OP_KC:    begin opa = k_q;  opb = c_w;    end
      OP_PUPD:  begin opa = rb_q; opb = p_q;    end
      OP_OUT:   begin opa = c_w;  opb = est_q;  end
      default:  begin opa = '0;   opb = '0;     end
    endcase
  end

  // saturating add or subtract after a product
  always_comb begin
    case (op_q)
      OP_PPRED: post = sat_addsub(t_q, q_w, 1'b0);
      OP_DEN:   post = sat_addsub(t_q, r_w, 1'b0);
      OP_INNOV: post = sat_addsub(y_q, t_q, 1'b1);
      OP_EST:   post = sat_addsub(xp_q, t_q, 1'b0);
      OP_KC:    post = sat_addsub(ONE_W, t_q, 1'b1);
      default:  post = t_q;
    endcase
  end

  // two multiplier bits per cycle
  assign mul_add = (prod_q[0] ? {2'b00, mx_q} : '0) + (prod_q[1] ? {1'b0, mx_q, 1'b0} : '0);
  assign mul_sum = {2'b00, prod_q[PW-1:MW]} + mul_add;
  assign rnd     = {1'b0, prod_q} + ((PW+1)'(1) << (F - 1));

  // one quotient bit per cycle
  assign div_sh   = {rem_q, quo_q[W+F-1]};
  assign div_diff = div_sh - {1'b0, mx_q};
  assign div_ge   = div_sh >= {1'b0, mx_q};
  assign div_up   = rem_q >= (mx_q - rem_q);
  assign quo_up   = {1'b0, quo_q} + (W+F+1)'(div_up);

  assign limit = WMAX + W'(neg_q);
  assign over  = (|prod_q[PW-1:W]) || (prod_q[W-1:0] > limit);
  assign mag_r = over ? limit : prod_q[W-1:0];

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    cnt_d       = cnt_q;
    fault_d     = fault_q;
    out_valid_d = out_valid_q;
    filtered_d  = filtered_q;
    fault_out_d = fault_out_q;
    a_coef_d    = a_coef_q;
    c_coef_d    = c_coef_q;
    q_noise_d   = q_noise_q;
    r_noise_d   = r_noise_q;
    est_d       = est_q;
    pvar_d      = pvar_q;
    y_d         = y_q;
    sq_d        = sq_q;
    xp_d        = xp_q;
    p_d         = p_q;
    ra_d        = ra_q;
    rb_d        = rb_q;
    k_d         = k_q;
    t_d         = t_q;
    mx_d        = mx_q;
    neg_d       = neg_q;
    prod_d      = prod_q;
    rem_d       = rem_q;
    quo_d       = quo_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    if (cfg_wr) begin
      est_d  = '0;
      pvar_d = q_w;
      case (cfg_idx)
        skf_pkg::REG_A_COEF:  a_coef_d = pwdata;
        skf_pkg::REG_C_COEF:  c_coef_d = pwdata;
        skf_pkg::REG_Q_NOISE: begin
          q_noise_d = pwdata[30:0];
          pvar_d    = sat_in({1'b0, pwdata[30:0]});
        end
        skf_pkg::REG_R_NOISE: r_noise_d = pwdata[30:0];
        default: ;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          y_d     = sat_in(measurement_i);
          op_d    = OP_AA;
          fault_d = 1'b0;
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: begin
        neg_d = opa[W-1] ^ opb[W-1];
        if (op_q == OP_GAIN) begin
          if (rb_q == '0) begin
            // zero denominator: no gain, no correction
            k_d     = '0;
            fault_d = 1'b1;
            op_d    = op_e'(op_q + 4'd1);
          end else begin
            rem_d   = '0;
            quo_d   = {mag(opa), {F{1'b0}}};
            mx_d    = mag(opb);
            cnt_d   = CW'(DSTEPS - 1);
            state_d = ST_DIV;
          end
        end else begin
          mx_d    = mag(opa);
          prod_d  = PW'(mag(opb));
          cnt_d   = CW'(STEPS - 1);
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_d = {mul_sum, prod_q[MW-1:2]};
        cnt_d  = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = ST_MRND;
        end
      end
      ST_MRND: begin
        prod_d  = PW'(rnd[PW:F]);
        state_d = ST_FIN;
      end
      ST_DIV: begin
        rem_d = div_ge ? div_diff[W-1:0] : div_sh[W-1:0];
        quo_d = {quo_q[W+F-2:0], div_ge};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = ST_DRND;
        end
      end
      ST_DRND: begin
        // fold quotient overflow into one bit above the word
        prod_d  = PW'({|quo_up[W+F:W], quo_up[W-1:0]});
        state_d = ST_FIN;
      end
      ST_FIN: begin
        t_d     = neg_q ? (W'(0) - mag_r) : mag_r;
        state_d = ST_POST;
      end
      ST_POST: begin
        state_d = ST_SETUP;
        op_d    = op_e'(op_q + 4'd1);
        case (op_q)
          OP_AA:    sq_d   = post;
          OP_XP:    xp_d   = post;
          OP_PPRED: p_d    = post;
          OP_CC:    sq_d   = post;
          OP_NUM:   ra_d   = post;
          OP_DEN:   rb_d   = post;
          OP_GAIN:  k_d    = post;
          OP_INNOV: ra_d   = post;
          OP_EST:   est_d  = post;
          OP_KC:    rb_d   = post;
          OP_PUPD:  pvar_d = post;
          OP_OUT: begin
            op_d    = op_q;
            state_d = ST_DONE;
          end
          default: ;
        endcase
      end
      ST_DONE: begin
        // hold until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          filtered_d  = sat_out(t_q);
          fault_out_d = fault_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_AA;
      cnt_q       <= '0;
      fault_q     <= 1'b0;
      out_valid_q <= 1'b0;
      filtered_q  <= '0;
      fault_out_q <= 1'b0;
      a_coef_q    <= skf_pkg::A_COEF_RESET;
      c_coef_q    <= skf_pkg::C_COEF_RESET;
      q_noise_q   <= skf_pkg::Q_NOISE_RESET;
      r_noise_q   <= skf_pkg::R_NOISE_RESET;
      est_q       <= '0;
      pvar_q      <= sat_in({1'b0, skf_pkg::Q_NOISE_RESET});
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      cnt_q       <= cnt_d;
      fault_q     <= fault_d;
      out_valid_q <= out_valid_d;
      filtered_q  <= filtered_d;
      fault_out_q <= fault_out_d;
      a_coef_q    <= a_coef_d;
      c_coef_q    <= c_coef_d;
      q_noise_q   <= q_noise_d;
      r_noise_q   <= r_noise_d;
      est_q       <= est_d;
      pvar_q      <= pvar_d;
    end
  end

  always_ff @(posedge clk_i) begin
    y_q    <= y_d;
    sq_q   <= sq_d;
    xp_q   <= xp_d;
    p_q    <= p_d;
    ra_q   <= ra_d;
    rb_q   <= rb_d;
    k_q    <= k_d;
    t_q    <= t_d;
    mx_q   <= mx_d;
    neg_q  <= neg_d;
    prod_q <= prod_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
  end

  assign in_stall_o     = (state_q != ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign filtered_o     = filtered_q;
  assign divide_fault_o = fault_out_q;

endmodule

### sv/skf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skf_checker
// Port-level checks on the scalar Kalman filter, bound to the top level.
// ----------------------------------------------------------------------------
module skf_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [skf_pkg::FIELD_W-1:0] filtered_o,
  input logic                        divide_fault_o,
  input logic                        pready
);

  // an accepted word keeps the block busy for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("block took a word and did not go busy");

  // a new result only appears at the end of a busy period
  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without work in progress");

  // a stalled result is held
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(filtered_o) && $stable(divide_fault_o)))
    else $error("stalled result word changed");

  // register port never inserts wait states
  a_no_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("register port not ready");

endmodule

bind scalar_kalman_filter skf_checker u_skf_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .filtered_o     (filtered_o),
  .divide_fault_o (divide_fault_o),
  .pready         (pready)
);
